// File: src/rph_pkg.sv
// Shared types, constants and fixed-point helpers for the ray/polygon hit block.
`timescale 1ns / 1ps
package rph_pkg;

    localparam int CW = 32;   // coordinate width
    localparam int FB = 16;   // fraction bits

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [2*CW:0] wide_t;

    typedef enum logic [1:0] {
        STATUS_HIT      = 2'd0,
        STATUS_PARALLEL = 2'd1,
        STATUS_BEHIND   = 2'd2,
        STATUS_OUTSIDE  = 2'd3
    } status_t;

    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_VERTEX = 1'b1;

    localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

    function automatic coord_t sat_w(input wide_t v);
        coord_t r;
        if (!v[2*CW] && (|v[2*CW-1:CW-1]))
            r = CMAX;
        else if (v[2*CW] && !(&v[2*CW-1:CW-1]))
            r = CMIN;
        else
            r = v[CW-1:0];
        return r;
    endfunction

    function automatic coord_t fadd(input coord_t a, input coord_t b);
        wide_t s;
        s = wide_t'(a) + wide_t'(b);
        return sat_w(s);
    endfunction

    function automatic coord_t fsub(input coord_t a, input coord_t b);
        wide_t s;
        s = wide_t'(a) - wide_t'(b);
        return sat_w(s);
    endfunction

    // exact product, floor shift, saturate
    function automatic coord_t fmul(input coord_t a, input coord_t b);
        logic signed [2*CW-1:0] p;
        logic signed [2*CW-1:0] sh;
        p  = (2*CW)'(a) * (2*CW)'(b);
        sh = p >>> FB;
        return sat_w(wide_t'(sh));
    endfunction

    function automatic coord_t sel3(input coord_t v0, input coord_t v1, input coord_t v2,
                                    input logic [1:0] idx);
        coord_t r;
        case (idx)
            2'd0:    r = v0;
            2'd1:    r = v1;
            default: r = v2;
        endcase
        return r;
    endfunction

    function automatic logic [CW:0] mag(input coord_t a);
        logic [CW:0] e;
        e = (CW+1)'(a);
        return a[CW-1] ? (CW+1)'(-e) : e;
    endfunction

endpackage

// File: src/rph_ifs.sv
// Request and response channel interfaces of the ray/polygon hit block.
`timescale 1ns / 1ps
interface rph_req_if;
    logic            valid;
    logic            ready;
    logic            req_type;
    rph_pkg::coord_t pos_x;
    rph_pkg::coord_t pos_y;
    rph_pkg::coord_t pos_z;
    rph_pkg::coord_t dir_x;
    rph_pkg::coord_t dir_y;
    rph_pkg::coord_t dir_z;
    rph_pkg::coord_t normal_x;
    rph_pkg::coord_t normal_y;
    rph_pkg::coord_t normal_z;
    logic            last;

    modport source (output valid, req_type, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                    normal_x, normal_y, normal_z, last, input ready);
    modport sink (input valid, req_type, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                  normal_x, normal_y, normal_z, last, output ready);
endinterface

interface rph_rsp_if;
    logic            valid;
    logic            ready;
    logic [1:0]      status;
    rph_pkg::coord_t hit_x;
    rph_pkg::coord_t hit_y;
    rph_pkg::coord_t hit_z;

    modport source (output valid, status, hit_x, hit_y, hit_z, input ready);
    modport sink (input valid, status, hit_x, hit_y, hit_z, output ready);
endinterface

// File: src/rph_div.sv
// Iterative restoring divider: saturated (a << FB) / b, truncated toward zero.
`timescale 1ns / 1ps
module rph_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rph_pkg::coord_t num,
    input  rph_pkg::coord_t den,
    output logic            done,
    output rph_pkg::coord_t quot
);
    import rph_pkg::*;

    localparam int NW   = CW + FB;
    localparam int CNTW = $clog2(NW);
    localparam logic [NW-1:0] LIM = NW'(1) << (CW - 1);

    logic [NW-1:0]   n_reg;
    logic [NW-1:0]   q_reg;
    logic [CW:0]     d_reg;
    logic [CW:0]     rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic            neg_reg;
    logic            zero_reg;

    logic [CW+1:0]   rem_sh;
    logic            fits;
    logic [CW:0]     num_mag;

    assign rem_sh  = {rem_reg, n_reg[NW-1]};
    assign fits    = rem_sh >= {1'b0, d_reg};
    assign num_mag = mag(num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                n_reg    <= {num_mag[CW-1:0], {FB{1'b0}}};
                d_reg    <= mag(den);
                rem_reg  <= '0;
                q_reg    <= '0;
                neg_reg  <= num[CW-1] ^ den[CW-1];
                zero_reg <= (den == '0);
                cnt_reg  <= CNTW'(NW - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? (CW+1)'(rem_sh - {1'b0, d_reg}) : rem_sh[CW:0];
                q_reg   <= {q_reg[NW-2:0], fits};
                n_reg   <= {n_reg[NW-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (zero_reg)
            quot = '0;
        else if (neg_reg)
            quot = (q_reg > LIM) ? CMIN : coord_t'(-q_reg[CW-1:0]);
        else
            quot = (q_reg >= LIM) ? CMAX : coord_t'(q_reg[CW-1:0]);
    end

    assign done = done_reg;

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg && $past(busy_reg);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("div done without run");

    property p_start_busy;
        @(posedge clk) disable iff (!rst_n) start |=> busy_reg;
    endproperty
    a_start_busy: assert property (p_start_busy) else $error("div start not taken");

    property p_no_restart;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> !start;
    endproperty
    a_no_restart: assert property (p_no_restart) else $error("div restarted while busy");

endmodule

// File: src/ray_polygon_hit.sv
// Top level of the ray against planar polygon crossing test.
`timescale 1ns / 1ps
// A header transaction (req_type 0) loads ray origin, direction and plane normal. Vertex
// transactions follow; the one with last set yields one response. The first vertex of a
// polygon runs up to two dot products and one divide; each later vertex and the closing
// edge skip the divide when the edge does not straddle the test line and run one divide
// when it does. The divider is iterative and takes 48 steps. The request side is not ready
// while a vertex is in work or while a finished response still waits to be taken and
// another is due.
module ray_polygon_hit (
    input  logic clk,
    input  logic rst_n,
    rph_req_if.sink   req,
    rph_rsp_if.source rsp
);
    import rph_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_DEN_M, S_DEN_A, S_DEN_CHK, S_NUM_S, S_NUM_M, S_NUM_A,
        S_NUM_CHK, S_NDIV, S_HIT_M, S_HIT_A, S_VDONE, S_E_CHK, S_E_SUB1, S_E_SUB2,
        S_EDIV, S_E_SUB3, S_E_MUL, S_E_ADD, S_E_CMP, S_E_END, S_FIN
    } state_t;

    state_t     state_reg;
    coord_t     org_reg [3];
    coord_t     dir_reg [3];
    coord_t     nrm_reg [3];
    coord_t     first_reg [3];
    coord_t     prev_reg [3];
    coord_t     cur_reg [3];
    coord_t     hit_reg [3];
    logic [1:0] axis_reg;
    logic       parity_reg;
    status_t    pstat_reg;
    logic       awaiting_reg;
    logic       last_reg;
    logic       closing_reg;
    logic [1:0] i_reg;
    coord_t     mprod_reg;
    coord_t     acc_reg;
    coord_t     den_reg;
    coord_t     tmp_reg;
    coord_t     s_reg;
    logic       div_start_reg;
    coord_t     div_a_reg;
    coord_t     div_b_reg;
    logic       out_valid_reg;
    status_t    out_status_reg;
    coord_t     out_x_reg;
    coord_t     out_y_reg;
    coord_t     out_z_reg;

    logic       div_done;
    coord_t     div_q;
    logic       fin_fire;

    rph_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_a_reg),
        .den   (div_b_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // projection axes
    logic [1:0]  t_ax;
    logic [1:0]  c_ax;
    logic [1:0]  axis_next;
    logic [CW:0] m0;
    logic [CW:0] m1;
    logic [CW:0] m2;
    coord_t      a_t, a_c, b_t, b_c, p_t, p_c;
    coord_t      org_i, dir_i, nrm_i, first_i;

    assign t_ax = (axis_reg == 2'd1) ? 2'd2 : 2'd1;
    assign c_ax = (axis_reg == 2'd0) ? 2'd2 : 2'd0;
    assign m0 = mag(nrm_reg[0]);
    assign m1 = mag(nrm_reg[1]);
    assign m2 = mag(nrm_reg[2]);
    assign axis_next = (m0 > m1 && m0 > m2) ? 2'd0 : ((m1 > m2) ? 2'd1 : 2'd2);

    // response register free to take the finished polygon
    assign fin_fire = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        a_t = sel3(prev_reg[0], prev_reg[1], prev_reg[2], t_ax);
        a_c = sel3(prev_reg[0], prev_reg[1], prev_reg[2], c_ax);
        if (closing_reg)
        begin
            b_t = sel3(first_reg[0], first_reg[1], first_reg[2], t_ax);
            b_c = sel3(first_reg[0], first_reg[1], first_reg[2], c_ax);
        end
        else
        begin
            b_t = sel3(cur_reg[0], cur_reg[1], cur_reg[2], t_ax);
            b_c = sel3(cur_reg[0], cur_reg[1], cur_reg[2], c_ax);
        end
        p_t     = sel3(hit_reg[0], hit_reg[1], hit_reg[2], t_ax);
        p_c     = sel3(hit_reg[0], hit_reg[1], hit_reg[2], c_ax);
        org_i   = sel3(org_reg[0], org_reg[1], org_reg[2], i_reg);
        dir_i   = sel3(dir_reg[0], dir_reg[1], dir_reg[2], i_reg);
        nrm_i   = sel3(nrm_reg[0], nrm_reg[1], nrm_reg[2], i_reg);
        first_i = sel3(first_reg[0], first_reg[1], first_reg[2], i_reg);
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.hit_x  = out_x_reg;
    assign rsp.hit_y  = out_y_reg;
    assign rsp.hit_z  = out_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int k = 0; k < 3; k++)
            begin
                org_reg[k] <= '0;
                dir_reg[k] <= '0;
                nrm_reg[k] <= '0;
                hit_reg[k] <= '0;
            end
            axis_reg      <= 2'd0;
            parity_reg    <= 1'b0;
            pstat_reg     <= STATUS_HIT;
            awaiting_reg  <= 1'b1;
            last_reg      <= 1'b0;
            closing_reg   <= 1'b0;
            i_reg         <= 2'd0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (rsp.ready && !fin_fire)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req.req_type == REQ_HEADER)
                        begin
                            org_reg[0]   <= req.pos_x;
                            org_reg[1]   <= req.pos_y;
                            org_reg[2]   <= req.pos_z;
                            dir_reg[0]   <= req.dir_x;
                            dir_reg[1]   <= req.dir_y;
                            dir_reg[2]   <= req.dir_z;
                            nrm_reg[0]   <= req.normal_x;
                            nrm_reg[1]   <= req.normal_y;
                            nrm_reg[2]   <= req.normal_z;
                            awaiting_reg <= 1'b1;
                            parity_reg   <= 1'b0;
                        end
                        else
                        begin
                            cur_reg[0]  <= req.pos_x;
                            cur_reg[1]  <= req.pos_y;
                            cur_reg[2]  <= req.pos_z;
                            last_reg    <= req.last;
                            closing_reg <= 1'b0;
                            state_reg   <= awaiting_reg ? S_START : S_E_CHK;
                        end
                    end
                end
                S_START:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        first_reg[k] <= cur_reg[k];
                        prev_reg[k]  <= cur_reg[k];
                        hit_reg[k]   <= '0;
                    end
                    axis_reg     <= axis_next;
                    parity_reg   <= 1'b0;
                    awaiting_reg <= 1'b0;
                    i_reg        <= 2'd0;
                    state_reg    <= S_DEN_M;
                end
                S_DEN_M:
                begin
                    mprod_reg <= fmul(nrm_i, dir_i);
                    state_reg <= S_DEN_A;
                end
                S_DEN_A:
                begin
                    acc_reg <= (i_reg == 2'd0) ? mprod_reg : fadd(acc_reg, mprod_reg);
                    if (i_reg == 2'd2)
                    begin
                        state_reg <= S_DEN_CHK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 2'd1;
                        state_reg <= S_DEN_M;
                    end
                end
                S_DEN_CHK:
                begin
                    den_reg <= acc_reg;
                    i_reg   <= 2'd0;
                    if (acc_reg == '0)
                    begin
                        pstat_reg <= STATUS_PARALLEL;
                        state_reg <= S_VDONE;
                    end
                    else
                    begin
                        state_reg <= S_NUM_S;
                    end
                end
                S_NUM_S:
                begin
                    tmp_reg   <= fsub(first_i, org_i);
                    state_reg <= S_NUM_M;
                end
                S_NUM_M:
                begin
                    mprod_reg <= fmul(nrm_i, tmp_reg);
                    state_reg <= S_NUM_A;
                end
                S_NUM_A:
                begin
                    acc_reg <= (i_reg == 2'd0) ? mprod_reg : fadd(acc_reg, mprod_reg);
                    if (i_reg == 2'd2)
                    begin
                        state_reg <= S_NUM_CHK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 2'd1;
                        state_reg <= S_NUM_S;
                    end
                end
                S_NUM_CHK:
                begin
                    if (acc_reg != '0 && (acc_reg[CW-1] != den_reg[CW-1]))
                    begin
                        pstat_reg <= STATUS_BEHIND;
                        state_reg <= S_VDONE;
                    end
                    else
                    begin
                        pstat_reg     <= STATUS_HIT;
                        div_a_reg     <= acc_reg;
                        div_b_reg     <= den_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_NDIV;
                    end
                end
                S_NDIV:
                begin
                    if (div_done)
                    begin
                        s_reg     <= div_q;
                        i_reg     <= 2'd0;
                        state_reg <= S_HIT_M;
                    end
                end
                S_HIT_M:
                begin
                    mprod_reg <= fmul(dir_i, s_reg);
                    state_reg <= S_HIT_A;
                end
                S_HIT_A:
                begin
                    hit_reg[i_reg] <= fadd(org_i, mprod_reg);
                    if (i_reg == 2'd2)
                    begin
                        state_reg <= S_VDONE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 2'd1;
                        state_reg <= S_HIT_M;
                    end
                end
                S_VDONE:
                begin
                    // first vertex has no edge of its own; only the closing edge if last
                    closing_reg <= 1'b1;
                    state_reg   <= last_reg ? S_E_CHK : S_IDLE;
                end
                S_E_CHK:
                begin
                    state_reg <= ((a_t > p_t) == (b_t > p_t)) ? S_E_END : S_E_SUB1;
                end
                S_E_SUB1:
                begin
                    tmp_reg   <= fsub(a_c, b_c);
                    state_reg <= S_E_SUB2;
                end
                S_E_SUB2:
                begin
                    div_a_reg     <= tmp_reg;
                    div_b_reg     <= fsub(a_t, b_t);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_EDIV;
                end
                S_EDIV:
                begin
                    if (div_done)
                    begin
                        s_reg     <= div_q;
                        state_reg <= S_E_SUB3;
                    end
                end
                S_E_SUB3:
                begin
                    tmp_reg   <= fsub(p_t, b_t);
                    state_reg <= S_E_MUL;
                end
                S_E_MUL:
                begin
                    mprod_reg <= fmul(s_reg, tmp_reg);
                    state_reg <= S_E_ADD;
                end
                S_E_ADD:
                begin
                    s_reg     <= fadd(mprod_reg, b_c);
                    state_reg <= S_E_CMP;
                end
                S_E_CMP:
                begin
                    if (s_reg < p_c)
                        parity_reg <= ~parity_reg;
                    state_reg <= S_E_END;
                end
                S_E_END:
                begin
                    if (closing_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                            prev_reg[k] <= cur_reg[k];
                        closing_reg <= 1'b1;
                        state_reg   <= last_reg ? S_E_CHK : S_IDLE;
                    end
                end
                S_FIN:
                begin
                    if (fin_fire)
                    begin
                        if (pstat_reg != STATUS_HIT)
                        begin
                            out_status_reg <= pstat_reg;
                            out_x_reg      <= '0;
                            out_y_reg      <= '0;
                            out_z_reg      <= '0;
                        end
                        else
                        begin
                            out_status_reg <= parity_reg ? STATUS_HIT : STATUS_OUTSIDE;
                            out_x_reg      <= hit_reg[0];
                            out_y_reg      <= hit_reg[1];
                            out_z_reg      <= hit_reg[2];
                        end
                        out_valid_reg <= 1'b1;
                        awaiting_reg  <= 1'b1;
                        parity_reg    <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    property p_div_done_waited;
        @(posedge clk) disable iff (!rst_n)
            div_done |-> (state_reg == S_NDIV || state_reg == S_EDIV);
    endproperty
    a_div_done_waited: assert property (p_div_done_waited) else $error("stray divide result");

    property p_fin_emits;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == S_FIN && (!out_valid_reg || rsp.ready))
            |=> out_valid_reg && awaiting_reg && !parity_reg;
    endproperty
    a_fin_emits: assert property (p_fin_emits) else $error("response not issued");

    property p_axis_legal;
        @(posedge clk) disable iff (!rst_n) !awaiting_reg |-> axis_reg != 2'd3;
    endproperty
    a_axis_legal: assert property (p_axis_legal) else $error("bad projection axis");

endmodule

// File: tb/sv/ray_polygon_hit_tb.sv
// Self-checking testbench for the ray against planar polygon crossing test.
`timescale 1ns / 1ps
module ray_polygon_hit_tb;
    import rph_pkg::*;

    typedef struct {
        logic   req_type;
        coord_t pos[3];
        coord_t dir[3];
        coord_t nrm[3];
        logic   last;
    } query_t;

    typedef struct {
        status_t status;
        coord_t  hit[3];
    } outcome_t;

    typedef struct {
        query_t   q;
        logic     typed;   // expected outcome written in the table
        outcome_t want;
    } row_t;

    logic clk;
    logic rst_n;
    rph_req_if req ();
    rph_rsp_if rsp ();

    ray_polygon_hit dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    // predictor state
    coord_t  m_org[3], m_dir[3], m_nrm[3];
    coord_t  m_first[3], m_prev[3], m_hitp[3];
    logic [1:0] m_axis;
    logic    m_parity;
    status_t m_plane;
    logic    m_fresh;

    outcome_t expected_hits[$];
    row_t     tbl[$];
    int       errors;
    logic     quiet;      // no idling in the final stretch
    logic     hold_long;  // receiver hold-off request

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void add_row(input query_t q, input logic typed, input outcome_t want);
        row_t r;
        r.q     = q;
        r.typed = typed;
        r.want  = want;
        tbl.insert(tbl.size(), r);
    endfunction

    // exact quotient (a << FB) / b, truncated toward zero, saturated
    function automatic coord_t qdiv(input coord_t a, input coord_t b);
        logic signed [127:0] n, d, q;
        if (b == 0)
            return '0;
        n = 128'(a) <<< FB;
        d = 128'(b);
        q = n / d;
        if (q > 128'(CMAX))
            return CMAX;
        if (q < 128'(CMIN))
            return CMIN;
        return q[CW-1:0];
    endfunction

    function automatic coord_t dot3(input coord_t a[3], input coord_t b[3]);
        coord_t acc;
        acc = fmul(a[0], b[0]);
        acc = fadd(acc, fmul(a[1], b[1]));
        return fadd(acc, fmul(a[2], b[2]));
    endfunction

    function automatic void edge_cross(input coord_t a[3], input coord_t b[3]);
        int t, c;
        coord_t s;
        t = (m_axis == 2'd1) ? 2 : 1;
        c = (m_axis == 2'd0) ? 2 : 0;
        if ((a[t] > m_hitp[t]) == (b[t] > m_hitp[t]))
            return;
        s = qdiv(fsub(a[c], b[c]), fsub(a[t], b[t]));
        s = fadd(fmul(s, fsub(m_hitp[t], b[t])), b[c]);
        if (s < m_hitp[c])
            m_parity = ~m_parity;
    endfunction

    function automatic void open_polygon(input coord_t v[3]);
        logic [CW:0] a0, a1, a2;
        coord_t den, num, r;
        coord_t rel[3];
        a0 = mag(m_nrm[0]);
        a1 = mag(m_nrm[1]);
        a2 = mag(m_nrm[2]);
        for (int i = 0; i < 3; i++)
        begin
            m_first[i] = v[i];
            m_prev[i]  = v[i];
            m_hitp[i]  = '0;
        end
        if (a0 > a1 && a0 > a2)
            m_axis = 2'd0;
        else if (a1 > a2)
            m_axis = 2'd1;
        else
            m_axis = 2'd2;
        m_parity = 1'b0;
        m_fresh  = 1'b0;
        den = dot3(m_nrm, m_dir);
        if (den == 0)
        begin
            m_plane = STATUS_PARALLEL;
            return;
        end
        for (int i = 0; i < 3; i++)
            rel[i] = fsub(v[i], m_org[i]);
        num = dot3(m_nrm, rel);
        if (num != 0 && ((num < 0) != (den < 0)))
        begin
            m_plane = STATUS_BEHIND;
            return;
        end
        m_plane = STATUS_HIT;
        r = qdiv(num, den);
        for (int i = 0; i < 3; i++)
            m_hitp[i] = fadd(m_org[i], fmul(m_dir[i], r));
    endfunction

    // returns 1 when the query closes a polygon and fills o
    function automatic logic predict_hit(input query_t q, output outcome_t o);
        o.status = STATUS_HIT;
        for (int i = 0; i < 3; i++)
            o.hit[i] = '0;
        if (q.req_type == REQ_HEADER)
        begin
            m_org = q.pos;
            m_dir = q.dir;
            m_nrm = q.nrm;
            m_fresh  = 1'b1;
            m_parity = 1'b0;
            return 1'b0;
        end
        if (m_fresh)
            open_polygon(q.pos);
        else
        begin
            edge_cross(m_prev, q.pos);
            m_prev = q.pos;
        end
        if (!q.last)
            return 1'b0;
        edge_cross(m_prev, m_first);
        if (m_plane != STATUS_HIT)
            o.status = m_plane;
        else
        begin
            o.status = m_parity ? STATUS_HIT : STATUS_OUTSIDE;
            o.hit = m_hitp;
        end
        m_fresh  = 1'b1;
        m_parity = 1'b0;
        return 1'b1;
    endfunction

    function automatic query_t mk_hdr(input coord_t ox, oy, oz, dx, dy, dz, nx, ny, nz);
        query_t q;
        q.req_type = REQ_HEADER;
        q.pos = '{ox, oy, oz};
        q.dir = '{dx, dy, dz};
        q.nrm = '{nx, ny, nz};
        q.last = 1'b0;
        return q;
    endfunction

    function automatic query_t mk_vtx(input coord_t x, y, z, input logic lst);
        query_t q;
        q = mk_hdr($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
        q.req_type = REQ_VERTEX;
        q.pos = '{x, y, z};
        q.last = lst;
        return q;
    endfunction

    function automatic coord_t rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 3) == 0 ? CMAX : CMIN;
            default: return coord_t'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
        endcase
    endfunction

    // idle burst now and then
    task automatic maybe_idle(output int n);
        n = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    endtask

    // valid stays up after acceptance until the next transaction or an idle gap
    task automatic send(input query_t q);
        int gap;
        maybe_idle(gap);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.req_type <= q.req_type;
        req.pos_x    <= q.pos[0];
        req.pos_y    <= q.pos[1];
        req.pos_z    <= q.pos[2];
        req.dir_x    <= q.dir[0];
        req.dir_y    <= q.dir[1];
        req.dir_z    <= q.dir[2];
        req.normal_x <= q.nrm[0];
        req.normal_y <= q.nrm[1];
        req.normal_z <= q.nrm[2];
        req.last     <= q.last;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    task automatic issue(input query_t q, input logic typed, input outcome_t want);
        outcome_t o;
        if (predict_hit(q, o))
        begin
            if (typed && (o.status != want.status || o.hit != want.hit))
            begin
                $error("table row disagrees: status exp %0d pred %0d", want.status, o.status);
                errors++;
            end
            expected_hits.insert(expected_hits.size(), o);
        end
        send(q);
    endtask

    // response side
    initial begin
        int gap;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                rsp.ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_long = 1'b0;
            end
            maybe_idle(gap);
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("unexpected response status %0d", rsp.status);
                errors++;
            end
            else
            begin
                outcome_t e;
                e = expected_hits.pop_front();
                if (rsp.status != e.status)
                begin
                    $error("status exp %0d got %0d", e.status, rsp.status);
                    errors++;
                end
                if (rsp.hit_x != e.hit[0])
                begin
                    $error("hit_x exp %0d got %0d", e.hit[0], rsp.hit_x);
                    errors++;
                end
                if (rsp.hit_y != e.hit[1])
                begin
                    $error("hit_y exp %0d got %0d", e.hit[1], rsp.hit_y);
                    errors++;
                end
                if (rsp.hit_z != e.hit[2])
                begin
                    $error("hit_z exp %0d got %0d", e.hit[2], rsp.hit_z);
                    errors++;
                end
            end
        end
    end

    // random polygon around a random plane, mostly well formed
    task automatic random_polygon(output int n_items);
        outcome_t none;
        coord_t cx, cy, cz;
        int nv;
        int dom;
        coord_t n[3];
        none.status = STATUS_HIT;
        none.hit = '{'0, '0, '0};
        dom = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
            n[i] = coord_t'($signed($urandom_range(0, 1 << FB)) - (1 << (FB - 1)));
        n[dom] = (1 << FB) + $urandom_range(0, 1 << FB);
        if ($urandom_range(0, 9) == 0)
            n = '{rnd_coord(), rnd_coord(), rnd_coord()};
        issue(mk_hdr(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_coord(), n[0], n[1], n[2]), 1'b0, none);
        nv = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
        n_items = nv + 1;
        cx = rnd_coord();
        cy = rnd_coord();
        cz = rnd_coord();
        for (int k = 0; k < nv; k++)
        begin
            if ($urandom_range(0, 4) == 0)
                issue(mk_vtx(rnd_coord(), rnd_coord(), rnd_coord(), k == nv - 1), 1'b0, none);
            else
                issue(mk_vtx(fadd(cx, coord_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB))),
                             fadd(cy, coord_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB))),
                             fadd(cz, coord_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB))),
                             k == nv - 1), 1'b0, none);
        end
    endtask

    localparam coord_t ONE = 1 << FB;

    initial begin
        row_t r;
        outcome_t z, none;
        int sent;
        int n_items;
        int waited;
        errors = 0;
        quiet = 1'b0;
        hold_long = 1'b0;
        m_org = '{'0, '0, '0};
        m_dir = m_org;
        m_nrm = m_org;
        m_first = m_org;
        m_prev = m_org;
        m_hitp = m_org;
        m_axis = 2'd0;
        m_parity = 1'b0;
        m_plane = STATUS_HIT;
        m_fresh = 1'b1;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = REQ_HEADER;
        req.pos_x = '0;
        req.pos_y = '0;
        req.pos_z = '0;
        req.dir_x = '0;
        req.dir_y = '0;
        req.dir_z = '0;
        req.normal_x = '0;
        req.normal_y = '0;
        req.normal_z = '0;
        req.last = 1'b0;
        z.status = STATUS_PARALLEL;
        z.hit = '{'0, '0, '0};
        none = z;

        // vertex before any header: zeros give a parallel ray
        add_row(mk_vtx(CMAX, CMIN, '0, 1'b1), 1'b1, z);
        // ray down -z through a unit square in z = 0, hit at (0.5, 0.5, 0)
        add_row(mk_hdr(ONE/2, ONE/2, ONE, '0, '0, -ONE, '0, '0, ONE), 1'b0, none);
        add_row(mk_vtx('0, '0, '0, 1'b0), 1'b0, none);
        add_row(mk_vtx(ONE, '0, '0, 1'b0), 1'b0, none);
        add_row(mk_vtx(ONE, ONE, '0, 1'b0), 1'b0, none);
        add_row(mk_vtx('0, ONE, '0, 1'b1), 1'b0, none);
        // same plane, point outside a triangle
        add_row(mk_hdr(3*ONE, ONE/2, ONE, '0, '0, -ONE, '0, '0, ONE), 1'b0, none);
        add_row(mk_vtx('0, '0, '0, 1'b0), 1'b0, none);
        add_row(mk_vtx(ONE, '0, '0, 1'b0), 1'b0, none);
        add_row(mk_vtx('0, ONE, '0, 1'b1), 1'b0, none);
        // parallel ray
        add_row(mk_hdr('0, '0, ONE, ONE, '0, '0, '0, '0, ONE), 1'b0, none);
        add_row(mk_vtx('0, '0, '0, 1'b1), 1'b1, z);
        // plane behind the ray
        z.status = STATUS_BEHIND;
        add_row(mk_hdr('0, '0, ONE, '0, '0, ONE, '0, '0, ONE), 1'b0, none);
        add_row(mk_vtx('0, '0, '0, 1'b1), 1'b1, z);
        // header abandons a polygon; x-dominant normal, extreme values
        add_row(mk_hdr(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, ONE, ONE), 1'b0, none);
        add_row(mk_vtx(CMAX, CMAX, CMAX, 1'b0), 1'b0, none);
        add_row(mk_hdr(-ONE, ONE/4, ONE/4, ONE, '0, '0, ONE, ONE/2, '0), 1'b0, none);
        add_row(mk_vtx('0, '0, '0, 1'b0), 1'b0, none);
        add_row(mk_vtx('0, ONE, '0, 1'b0), 1'b0, none);
        add_row(mk_vtx('0, '0, ONE, 1'b1), 1'b0, none);
        // y-dominant normal, single vertex polygon
        add_row(mk_hdr(ONE, -ONE, ONE, '0, ONE, '0, '0, -2*ONE, ONE), 1'b0, none);
        add_row(mk_vtx(CMIN, CMIN, CMIN, 1'b1), 1'b0, none);
        // saturated extremes everywhere
        add_row(mk_hdr(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX), 1'b0, none);
        add_row(mk_vtx(CMIN, CMAX, CMIN, 1'b0), 1'b0, none);
        add_row(mk_vtx(-1, 1, -1, 1'b1), 1'b0, none);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (tbl[i])
        begin
            r = tbl[i];
            issue(r.q, r.typed, r.want);
        end

        sent = tbl.size();
        while (sent < 1050)
        begin
            if (sent > 300 && sent < 320)
                hold_long = 1'b1;
            if (sent > 950)
                quiet = 1'b1;
            if ($urandom_range(0, 15) == 0)
            begin
                issue(mk_vtx(rnd_coord(), rnd_coord(), rnd_coord(), $urandom_range(0, 1)),
                      1'b0, none);
                sent++;
            end
            else
            begin
                random_polygon(n_items);
                sent += n_items;
            end
        end
        req.valid <= 1'b0;

        waited = 0;
        while (expected_hits.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_hits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
src/rph_pkg.sv
src/rph_ifs.sv
src/rph_div.sv
src/ray_polygon_hit.sv
tb/sv/ray_polygon_hit_tb.sv
